// File: rtl/core/brt_pkg.sv
`default_nettype none
package brt_pkg;

  localparam int SLOTS         = 25;
  localparam int AGE_TIMEOUT   = 100;
  localparam int LOCKOUT_TICKS = 200;
  localparam int IDX_W         = 5;
  localparam int ADDR_W        = $clog2(SLOTS);
  localparam int QDEPTH        = 2;

  localparam logic [7:0] KNOWN_FLAGS = 8'h1A;
  localparam logic [6:0] STR_LO_OFF  = 7'd30;
  localparam logic [6:0] STR_HI_OFF  = 7'd72;
  localparam logic [8:0] BRIGHT_MIN  = 9'd16;
  localparam logic [4:0] BRIGHT_MUL  = 5'd23;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + AGE_TIMEOUT - 1) / AGE_TIMEOUT);

  localparam logic [2:0] REG_RSSI_EN      = 3'd0;
  localparam logic [2:0] REG_FADEOUT_EN   = 3'd1;
  localparam logic [2:0] REG_PERSIST_EN   = 3'd2;
  localparam logic [2:0] REG_DEVTYPE_VIS  = 3'd3;
  localparam logic [2:0] REG_FADE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_FADE_LIMIT_O = 3'd5;

  localparam logic [7:0] GAMMA [64] = '{
    8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0b,8'h0d,8'h0f,8'h11,8'h13,8'h16,
    8'h1a,8'h1c,8'h1d,8'h1f,8'h22,8'h25,8'h28,8'h2e,8'h34,8'h38,8'h3c,8'h40,8'h44,8'h48,8'h4b,8'h4f,
    8'h55,8'h5a,8'h5f,8'h64,8'h69,8'h6d,8'h72,8'h77,8'h7d,8'h80,8'h88,8'h8d,8'h94,8'h9a,8'ha0,8'ha7,
    8'hac,8'hb0,8'hb9,8'hbf,8'hc6,8'hcb,8'hcf,8'hd6,8'he1,8'he9,8'hed,8'hf1,8'hf6,8'hfa,8'hfe,8'hff
  };

  typedef struct packed {
    logic              op;
    logic [15:0]       short_id;
    logic signed [7:0] strength;
    logic [1:0]        addr_type;
    logic              flags_present;
    logic [7:0]        flags_byte;
    logic              blink_phase;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  pixel_index;
    logic [7:0]  brightness;
    logic        peak_hit;
    logic [4:0]  active_count;
    logic [4:0]  other_active;
    logic [4:0]  strongest_slot;
    logic [31:0] seen_total;
    logic [31:0] other_seen_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        op;
    logic [15:0] short_id;
    logic        other;
    logic        reorder;
    logic [6:0]  str7;
    logic        phase;
  } job_t;

  typedef struct packed {
    logic       rssi_brightness_en;
    logic       fadeout_en;
    logic       persistence_en;
    logic       devtype_visualize;
    logic [6:0] fade_age_limit;
    logic [6:0] fade_age_limit_other;
  } cfg_t;

  typedef struct packed {
    logic [15:0]      id;
    logic [7:0]       cs;
    logic [7:0]       age;
    logic [IDX_W-1:0] older;
    logic [IDX_W-1:0] newer;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/brt_ram.sv
`default_nettype none
module brt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/brt_front.sv
`default_nettype none
module brt_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire brt_pkg::in_item_t   item,
  input  wire brt_pkg::back_stat_t stat,
  output logic                     q_valid,
  output brt_pkg::job_t            q_item
);
  import brt_pkg::*;

  job_t       entries [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  job_t       job;
  logic       push;

  always_comb begin
    job.op       = item.op;
    job.short_id = item.short_id;
    job.other    = (item.addr_type != 2'd0) || !item.flags_present ||
                   (item.flags_byte != KNOWN_FLAGS);
    job.reorder  = (item.strength == -8'sd128);
    job.str7     = item.strength[7] ? item.strength[6:0] : 7'h7f;
    job.phase    = item.blink_phase;
  end

  assign busy    = (count == 2'(QDEPTH)) || stat.clearing;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= job;
        wr_ptr          <= ~wr_ptr;
      end
      if (stat.pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(stat.pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/brt_bright.sv
`default_nettype none
module brt_bright (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [7:0]    cs,
  input  wire logic [7:0]    age,
  input  wire logic          phase,
  input  wire brt_pkg::cfg_t cfg,
  output logic               done,
  output logic [7:0]         brightness
);
  import brt_pkg::*;

  logic [5:0]  off;
  logic [10:0] scaled;
  logic [8:0]  vt;
  logic [7:0]  v0;
  logic        dark;
  logic [7:0]  f0;
  logic [6:0]  limit;

  logic [7:0]  va;
  logic [7:0]  fa;
  logic [15:0] pb;
  logic [7:0]  qc;
  logic [RECIP_W+15:0] recip_prod;
  logic [2:0]  vld;

  always_comb begin
    if (cs[6:0] < STR_LO_OFF) begin
      off = 6'd0;
    end else if (cs[6:0] > STR_HI_OFF) begin
      off = 6'(STR_HI_OFF - STR_LO_OFF);
    end else begin
      off = 6'(cs[6:0] - STR_LO_OFF);
    end
    scaled = 11'(off) * 11'(BRIGHT_MUL);
    vt     = 9'(scaled >> 2) + BRIGHT_MIN;
    v0     = cfg.rssi_brightness_en ? ((vt > 9'd255) ? 8'd255 : vt[7:0]) : 8'd255;
    limit  = cs[7] ? cfg.fade_age_limit_other : cfg.fade_age_limit;
    dark   = (age >= {1'b0, limit}) ||
             (cfg.persistence_en && cfg.devtype_visualize && cs[7] && phase);
    if (!cfg.fadeout_en) begin
      f0 = 8'(AGE_TIMEOUT);
    end else if (age >= 8'(AGE_TIMEOUT)) begin
      f0 = 8'd0;
    end else begin
      f0 = 8'(AGE_TIMEOUT) - age;
    end
  end

  assign recip_prod = (RECIP_W+16)'(pb) * (RECIP_W+16)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 3'd0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], go};
      done <= vld[2];
    end
    va         <= dark ? 8'd0 : v0;
    fa         <= f0;
    pb         <= 16'(va) * 16'(fa);
    qc         <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    brightness <= GAMMA[qc[7:2]];
  end

endmodule
`default_nettype wire

// File: rtl/core/brt_back.sv
`default_nettype none
module brt_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire brt_pkg::cfg_t   cfg,
  input  wire logic            q_valid,
  input  wire brt_pkg::job_t   q_item,
  output brt_pkg::back_stat_t  stat,
  output logic                 strobe,
  output brt_pkg::out_item_t   result
);
  import brt_pkg::*;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOOK  = 4'd2;
  localparam logic [3:0] ST_E_RD  = 4'd3;
  localparam logic [3:0] ST_E_WT  = 4'd4;
  localparam logic [3:0] ST_N_RD  = 4'd5;
  localparam logic [3:0] ST_N_WR  = 4'd6;
  localparam logic [3:0] ST_O_CHK = 4'd7;
  localparam logic [3:0] ST_O_WR  = 4'd8;
  localparam logic [3:0] ST_W_RD  = 4'd9;
  localparam logic [3:0] ST_W_WR  = 4'd10;
  localparam logic [3:0] ST_E_WR  = 4'd11;
  localparam logic [3:0] ST_BWAIT = 4'd12;
  localparam logic [3:0] ST_TRD   = 4'd13;
  localparam logic [3:0] ST_TCHK  = 4'd14;

  localparam logic [IDX_W-1:0] SLOTS_I = IDX_W'(SLOTS);

  logic [3:0]       state;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] n_link;
  logic [IDX_W-1:0] o_link;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] newest;
  logic [IDX_W-1:0] strongest_reg;
  logic [IDX_W-1:0] best_idx;
  logic [6:0]       best7;
  logic             best_valid;
  logic [IDX_W-1:0] live;
  logic [IDX_W-1:0] others;
  logic [7:0]       lockout;
  logic [31:0]      seen;
  logic [31:0]      other_seen;
  logic             miss;
  job_t             job;
  entry_t           e;
  entry_t           e_fin;
  entry_t           rd;
  entry_t           wdata;
  logic             we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;

  logic             b_go;
  logic [7:0]       b_cs;
  logic [7:0]       b_age;
  logic             b_done;
  logic [7:0]       b_val;
  logic             slot_live;

  assign rd        = entry_t'(rdata);
  assign slot_live = (rd.age <= 8'(AGE_TIMEOUT));

  always_comb begin
    e_fin = e;
    if (!job.reorder) begin
      e_fin.cs  = {job.other, job.str7};
      e_fin.age = 8'd0;
    end
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = e_fin;
    unique case (state)
      ST_CLR: begin
        we          = 1'b1;
        waddr       = cnt[ADDR_W-1:0];
        wdata.id    = 16'(cnt);
        wdata.cs    = 8'd0;
        wdata.age   = 8'd255;
        wdata.older = cnt - 1'b1;
        wdata.newer = cnt + 1'b1;
      end
      ST_LOOK, ST_TRD: begin
        if (cnt < SLOTS_I) begin
          raddr = cnt[ADDR_W-1:0];
        end
      end
      ST_E_RD: raddr = idx[ADDR_W-1:0];
      ST_N_RD: raddr = n_link[ADDR_W-1:0];
      ST_N_WR: begin
        we          = 1'b1;
        waddr       = n_link[ADDR_W-1:0];
        wdata       = rd;
        wdata.older = o_link;
      end
      ST_O_CHK: raddr = o_link[ADDR_W-1:0];
      ST_O_WR: begin
        we          = 1'b1;
        waddr       = o_link[ADDR_W-1:0];
        wdata       = rd;
        wdata.newer = n_link;
      end
      ST_W_RD: raddr = newest[ADDR_W-1:0];
      ST_W_WR: begin
        we          = 1'b1;
        waddr       = newest[ADDR_W-1:0];
        wdata       = rd;
        wdata.newer = idx;
      end
      ST_E_WR: begin
        we    = 1'b1;
        waddr = idx[ADDR_W-1:0];
      end
      ST_TCHK: begin
        we        = slot_live;
        waddr     = cnt[ADDR_W-1:0];
        wdata     = rd;
        wdata.age = rd.age + 8'd1;
      end
      default: begin
      end
    endcase
  end

  assign stat.clearing = (state == ST_CLR);
  assign stat.pop      = (state == ST_IDLE) && q_valid;

  brt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(ENTRY_W'(wdata)),
    .raddr(raddr),
    .rdata(rdata)
  );

  brt_bright u_bright (
    .clk       (clk),
    .rst       (rst),
    .go        (b_go),
    .cs        (b_cs),
    .age       (b_age),
    .phase     (job.phase),
    .cfg       (cfg),
    .done      (b_done),
    .brightness(b_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      cnt           <= '0;
      oldest        <= '0;
      newest        <= SLOTS_I - 1'b1;
      strongest_reg <= SLOTS_I;
      lockout       <= 8'd0;
      seen          <= 32'd0;
      other_seen    <= 32'd0;
      strobe        <= 1'b0;
      b_go          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      b_go   <= 1'b0;
      unique case (state)
        ST_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == SLOTS_I - 1'b1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            job        <= q_item;
            cnt        <= '0;
            live       <= '0;
            others     <= '0;
            best_valid <= 1'b0;
            state      <= q_item.op ? ST_TRD : ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (cnt != '0 && rd.id == job.short_id) begin
            idx   <= cnt - 1'b1;
            miss  <= 1'b0;
            state <= ST_E_RD;
          end else if (cnt == SLOTS_I) begin
            idx   <= (oldest < SLOTS_I) ? oldest : '0;
            miss  <= 1'b1;
            state <= ST_E_RD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_E_RD: state <= ST_E_WT;
        ST_E_WT: begin
          e <= '{id: (miss ? job.short_id : rd.id), cs: rd.cs, age: rd.age,
                 older: rd.older, newer: rd.newer};
          if (miss && lockout == 8'd0) begin
            seen       <= seen + 32'd1;
            other_seen <= other_seen + 32'(job.other);
          end
          n_link <= rd.newer;
          o_link <= rd.older;
          if (idx == newest) begin
            state <= ST_E_WR;
          end else if (rd.newer < SLOTS_I) begin
            state <= ST_N_RD;
          end else begin
            state <= ST_O_CHK;
          end
        end
        ST_N_RD: state <= ST_N_WR;
        ST_N_WR: state <= ST_O_CHK;
        ST_O_CHK: begin
          if (idx == oldest) begin
            oldest <= n_link;
            state  <= ST_W_RD;
          end else if (o_link < SLOTS_I) begin
            state <= ST_O_WR;
          end else begin
            state <= ST_W_RD;
          end
        end
        ST_O_WR: state <= ST_W_RD;
        ST_W_RD: state <= ST_W_WR;
        ST_W_WR: begin
          e      <= '{id: e.id, cs: e.cs, age: e.age, older: newest, newer: rd.newer};
          newest <= idx;
          state  <= ST_E_WR;
        end
        ST_E_WR: begin
          if (job.reorder) begin
            state <= ST_IDLE;
          end else begin
            b_go  <= 1'b1;
            b_cs  <= e_fin.cs;
            b_age <= 8'd0;
            state <= ST_BWAIT;
          end
        end
        ST_BWAIT: begin
          if (b_done) begin
            strobe <= 1'b1;
            if (job.op) begin
              result <= '{kind: 1'b0, pixel_index: cnt, brightness: b_val,
                          peak_hit: 1'b0, active_count: '0, other_active: '0,
                          strongest_slot: '0, seen_total: '0, other_seen_total: '0,
                          last: 1'b0};
              cnt    <= cnt + 1'b1;
              state  <= ST_TRD;
            end else begin
              result <= '{kind: 1'b0, pixel_index: idx, brightness: b_val,
                          peak_hit: (idx == strongest_reg), active_count: '0,
                          other_active: '0, strongest_slot: '0, seen_total: '0,
                          other_seen_total: '0, last: 1'b1};
              state  <= ST_IDLE;
            end
          end
        end
        ST_TRD: begin
          if (cnt == SLOTS_I) begin
            strongest_reg <= best_valid ? best_idx : SLOTS_I;
            if (live == SLOTS_I) begin
              lockout <= 8'(LOCKOUT_TICKS);
            end else if (lockout != 8'd0) begin
              lockout <= lockout - 8'd1;
            end
            strobe <= 1'b1;
            result <= '{kind: 1'b1, pixel_index: '0, brightness: '0, peak_hit: 1'b0,
                        active_count: live, other_active: others,
                        strongest_slot: (best_valid ? best_idx : SLOTS_I),
                        seen_total: seen, other_seen_total: other_seen, last: 1'b1};
            state  <= ST_IDLE;
          end else begin
            state <= ST_TCHK;
          end
        end
        ST_TCHK: begin
          if (slot_live) begin
            live   <= live + 1'b1;
            others <= others + IDX_W'(rd.cs[7]);
            if (!best_valid || rd.cs[6:0] > best7) begin
              best_valid <= 1'b1;
              best7      <= rd.cs[6:0];
              best_idx   <= cnt;
            end
            b_go  <= 1'b1;
            b_cs  <= rd.cs;
            b_age <= rd.age + 8'd1;
            state <= ST_BWAIT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_TRD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/beacon_recency_table_with_fade.sv
// Sighting: lookup scan over the slot RAM, link update, then the brightness pipeline.
// Tick: each slot is read; live slots are aged and sent through the brightness pipeline,
// each giving a pixel result, and a summary result follows the last slot.
// Two requests queue ahead of the back end; results cannot be stalled.
// Synchronous reset, then a pass over all SLOTS entries fills the slot RAM while busy is high.
`default_nettype none
module beacon_recency_table_with_fade (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire brt_pkg::in_item_t  item,
  output logic                    strobe,
  output brt_pkg::out_item_t      result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import brt_pkg::*;

  cfg_t       cfg;
  back_stat_t stat;
  logic       q_valid;
  job_t       q_item;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{rssi_brightness_en: 1'b1, fadeout_en: 1'b1, persistence_en: 1'b1,
               devtype_visualize: 1'b0, fade_age_limit: 7'd100,
               fade_age_limit_other: 7'd100};
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_RSSI_EN:      cfg.rssi_brightness_en   <= pwdata[0];
        REG_FADEOUT_EN:   cfg.fadeout_en           <= pwdata[0];
        REG_PERSIST_EN:   cfg.persistence_en       <= pwdata[0];
        REG_DEVTYPE_VIS:  cfg.devtype_visualize    <= pwdata[0];
        REG_FADE_LIMIT:   cfg.fade_age_limit       <= pwdata[6:0];
        REG_FADE_LIMIT_O: cfg.fade_age_limit_other <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_RSSI_EN:      prdata = 32'(cfg.rssi_brightness_en);
      REG_FADEOUT_EN:   prdata = 32'(cfg.fadeout_en);
      REG_PERSIST_EN:   prdata = 32'(cfg.persistence_en);
      REG_DEVTYPE_VIS:  prdata = 32'(cfg.devtype_visualize);
      REG_FADE_LIMIT:   prdata = 32'(cfg.fade_age_limit);
      REG_FADE_LIMIT_O: prdata = 32'(cfg.fade_age_limit_other);
      default:          prdata = 32'd0;
    endcase
  end

  brt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .stat   (stat),
    .q_valid(q_valid),
    .q_item (q_item)
  );

  brt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_valid(q_valid),
    .q_item (q_item),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule
`default_nettype wire

// File: rtl/core/brt_checker.sv
`default_nettype none
module brt_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               busy,
  input wire logic               strobe,
  input wire brt_pkg::out_item_t result
);
  import brt_pkg::*;

  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind |-> result.last)
    else $error("summary without last");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind |-> result.brightness == 8'd0 && result.pixel_index == 5'd0)
    else $error("summary carries pixel fields");

  a_pixel_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.kind |-> result.pixel_index < 5'(SLOTS) &&
      result.seen_total == 32'd0 && result.active_count == 5'd0)
    else $error("pixel result malformed");

endmodule

bind beacon_recency_table_with_fade brt_checker u_brt_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .strobe(strobe),
  .result(result)
);
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import brt_pkg::*;

  typedef enum logic {OP_SIGHT = 1'b0, OP_TICK = 1'b1} op_e;
  typedef enum logic {KIND_PIXEL = 1'b0, KIND_SUMMARY = 1'b1} kind_e;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic strobe;
  out_item_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  beacon_recency_table_with_fade uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .strobe(strobe), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // predictor state
  cfg_t m_cfg;
  logic [15:0] m_id [SLOTS];
  logic [7:0] m_cs [SLOTS];
  logic [7:0] m_age [SLOTS];
  logic [4:0] m_older [SLOTS];
  logic [4:0] m_newer [SLOTS];
  logic [4:0] m_oldest, m_newest, m_strongest;
  logic [7:0] m_lockout;
  logic [31:0] m_seen, m_seen_other;

  in_item_t pending_requests [$];
  out_item_t expected_results [$];
  int errors = 0;
  int accepted = 0;
  int n_results = 0;
  int n_ticks = 0;
  int idle_cycles = 0;
  bit sender_hold = 1'b0;

  function automatic logic [7:0] gamma_of(int v);
    logic [7:0] g [64];
    g = GAMMA;
    return g[(v >> 2) & 63];
  endfunction

  function automatic logic [7:0] pixel_level(int i, logic phase);
    logic oth;
    int lim, age, v, s;
    oth = m_cs[i][7];
    lim = oth ? m_cfg.fade_age_limit_other : m_cfg.fade_age_limit;
    age = m_age[i];
    if (age >= lim) return 8'd0;
    v = 255;
    if (m_cfg.rssi_brightness_en) begin
      s = int'(m_cs[i][6:0]) - 128;
      if (s < -98) s = -98;
      if (s > -56) s = -56;
      v = (((s + 98) * 23) >> 2) + 16;
      if (v > 255) v = 255;
    end
    if (m_cfg.persistence_en && m_cfg.devtype_visualize && oth && phase) return 8'd0;
    if (m_cfg.fadeout_en)
      v = (age >= AGE_TIMEOUT) ? 0 : v * (AGE_TIMEOUT - age) / AGE_TIMEOUT;
    return gamma_of(v);
  endfunction

  task automatic table_reset();
    m_cfg = '{1'b1, 1'b1, 1'b1, 1'b0, 7'd100, 7'd100};
    for (int i = 0; i < SLOTS; i++) begin
      m_id[i] = 16'(i);
      m_cs[i] = '0;
      m_age[i] = 8'd255;
      m_older[i] = 5'(i + 31);
      m_newer[i] = 5'(i + 1);
    end
    m_oldest = 0;
    m_newest = 5'(SLOTS - 1);
    m_strongest = 5'(SLOTS);
    m_lockout = 0;
    m_seen = 0;
    m_seen_other = 0;
  endtask

  task automatic move_to_newest(int idx);
    int n, o;
    if (idx == m_newest) return;
    n = m_newer[idx];
    o = m_older[idx];
    if (n < SLOTS) m_older[n] = 5'(o);
    if (idx == m_oldest) m_oldest = 5'(n);
    else if (o < SLOTS) m_newer[o] = 5'(n);
    m_newer[idx] = m_newer[m_newest];
    m_newer[m_newest] = 5'(idx);
    m_older[idx] = m_newest;
    m_newest = 5'(idx);
  endtask

  task automatic predict_request(in_item_t it);
    out_item_t r;
    int idx, s, best, live, others, strongest;
    logic oth;
    if (op_e'(it.op) == OP_SIGHT) begin
      s = it.strength;
      oth = (it.addr_type != 0) || !it.flags_present || (it.flags_byte != KNOWN_FLAGS);
      idx = SLOTS;
      for (int i = 0; i < SLOTS; i++)
        if (idx == SLOTS && m_id[i] == it.short_id) idx = i;
      if (idx == SLOTS) begin
        idx = (m_oldest < SLOTS) ? m_oldest : 0;
        m_id[idx] = it.short_id;
        if (m_lockout == 0) begin
          m_seen++;
          m_seen_other += oth;
        end
      end
      move_to_newest(idx);
      if (s == -128) return;
      if (s > -1) s = -1;
      m_cs[idx] = {oth, 7'(s + 128)};
      m_age[idx] = 0;
      r = '0;
      r.kind = KIND_PIXEL;
      r.pixel_index = 5'(idx);
      r.brightness = pixel_level(idx, it.blink_phase);
      r.peak_hit = (idx == m_strongest);
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      best = -129;
      live = 0;
      others = 0;
      strongest = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (m_age[i] <= AGE_TIMEOUT) begin
          live++;
          others += m_cs[i][7];
          m_age[i]++;
          r = '0;
          r.pixel_index = 5'(i);
          r.brightness = pixel_level(i, it.blink_phase);
          expected_results.push_back(r);
          if (int'(m_cs[i][6:0]) - 128 > best) begin
            best = int'(m_cs[i][6:0]) - 128;
            strongest = i;
          end
        end
      end
      m_strongest = 5'(strongest);
      if (live == SLOTS) m_lockout = 8'(LOCKOUT_TICKS);
      else if (m_lockout != 0) m_lockout--;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.active_count = 5'(live);
      r.other_active = 5'(others);
      r.strongest_slot = 5'(strongest);
      r.seen_total = m_seen;
      r.other_seen_total = m_seen_other;
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  // driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_request(item);
        accepted++;
        if (op_e'(item.op) == OP_TICK) n_ticks++;
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (!sender_hold && pending_requests.size() > 0) begin
        item <= pending_requests.pop_front();
        start <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && strobe) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d index=%0d", result.kind, result.pixel_index);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (result.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, result.kind); errors++; end
        if (result.pixel_index !== e.pixel_index) begin
          $error("pixel_index exp %0d got %0d", e.pixel_index, result.pixel_index);
          errors++; end
        if (result.brightness !== e.brightness) begin
          $error("brightness exp %0d got %0d", e.brightness, result.brightness);
          errors++; end
        if (result.peak_hit !== e.peak_hit) begin
          $error("peak_hit exp %0d got %0d", e.peak_hit, result.peak_hit);
          errors++; end
        if (result.active_count !== e.active_count) begin
          $error("active_count exp %0d got %0d", e.active_count, result.active_count);
          errors++; end
        if (result.other_active !== e.other_active) begin
          $error("other_active exp %0d got %0d", e.other_active, result.other_active);
          errors++; end
        if (result.strongest_slot !== e.strongest_slot) begin
          $error("strongest_slot exp %0d got %0d", e.strongest_slot, result.strongest_slot);
          errors++; end
        if (result.seen_total !== e.seen_total) begin
          $error("seen_total exp %0d got %0d", e.seen_total, result.seen_total);
          errors++; end
        if (result.other_seen_total !== e.other_seen_total) begin
          $error("other_seen_total exp %0d got %0d", e.other_seen_total,
                 result.other_seen_total);
          errors++; end
        if (result.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, result.last); errors++; end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_item_t sighting(logic [15:0] id, logic signed [7:0] st, bit known,
                                        logic phase);
    in_item_t it;
    it = '0;
    it.op = OP_SIGHT;
    it.short_id = id;
    it.strength = st;
    it.flags_present = 1'b1;
    it.flags_byte = KNOWN_FLAGS;
    it.blink_phase = phase;
    if (!known) begin
      it.addr_type = 2'($urandom_range(0, 3));
      it.flags_present = 1'($urandom);
      it.flags_byte = 8'($urandom);
      if (it.addr_type == 0 && it.flags_present && it.flags_byte == KNOWN_FLAGS)
        it.addr_type = 2'd3;
    end
    return it;
  endfunction

  function automatic in_item_t tick(logic phase);
    in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    it.op = OP_TICK;
    it.blink_phase = phase;
    return it;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RSSI_EN:      m_cfg.rssi_brightness_en = val[0];
      REG_FADEOUT_EN:   m_cfg.fadeout_en = val[0];
      REG_PERSIST_EN:   m_cfg.persistence_en = val[0];
      REG_DEVTYPE_VIS:  m_cfg.devtype_visualize = val[0];
      REG_FADE_LIMIT:   m_cfg.fade_age_limit = val[6:0];
      REG_FADE_LIMIT_O: m_cfg.fade_age_limit_other = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !start);
    @(posedge clk);
    wait (!busy && expected_results.size() == 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [15:0] pool [8];
    int r;
    logic signed [7:0] st;
    for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      st = ($urandom_range(0, 5) == 0) ? 8'sh80 : 8'($urandom);
      if (r < 15) pending_requests.push_back(tick(1'($urandom)));
      else if (r < 60)
        pending_requests.push_back(sighting(pool[$urandom_range(0, 7)], st,
                                            1'($urandom), 1'($urandom)));
      else pending_requests.push_back(sighting(16'($urandom), st, 1'($urandom),
                                               1'($urandom)));
    end
  endtask

  initial begin
    in_item_t it;
    table_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    pending_requests.push_back(sighting(16'h0000, 8'sh7f, 1'b1, 1'b0));
    pending_requests.push_back(sighting(16'hffff, 8'sh80, 1'b1, 1'b0));
    pending_requests.push_back(sighting(16'hffff, -8'sd98, 1'b0, 1'b1));
    pending_requests.push_back(sighting(16'h0005, -8'sd56, 1'b1, 1'b1));
    pending_requests.push_back(sighting(16'h0005, -8'sd127, 1'b0, 1'b0));
    pending_requests.push_back(sighting(16'ha5a5, -8'sd1, 1'b1, 1'b0));
    pending_requests.push_back(tick(1'b0));
    pending_requests.push_back(sighting(16'ha5a5, 8'sd0, 1'b1, 1'b0));
    pending_requests.push_back(sighting(16'h5a5a, -8'sd60, 1'b0, 1'b1));
    pending_requests.push_back(tick(1'b1));
    it = sighting(16'h1234, -8'sd70, 1'b1, 1'b0);
    it.flags_byte = 8'hff; it.addr_type = 2'd0;
    pending_requests.push_back(it);
    drain();

    reg_write(REG_DEVTYPE_VIS, 32'd1);
    reg_write(REG_FADE_LIMIT, 32'd3);
    reg_write(REG_FADE_LIMIT_O, 32'd127);
    for (int i = 0; i < 25; i++)
      pending_requests.push_back(sighting(16'(16'h4000 + i), 8'($urandom), 1'($urandom),
                                          1'b0));
    pending_requests.push_back(tick(1'b1));
    pending_requests.push_back(sighting(16'h7777, -8'sd50, 1'b0, 1'b1));
    pending_requests.push_back(tick(1'b0));
    sender_hold = 1'b0;
    random_phase(40);
    drain();

    reg_write(REG_RSSI_EN, 32'd0);
    reg_write(REG_FADEOUT_EN, 32'd0);
    reg_write(REG_PERSIST_EN, 32'd0);
    reg_write(REG_FADE_LIMIT, 32'd0);
    reg_write(REG_FADE_LIMIT_O, 32'd0);
    random_phase(40);
    drain();

    reg_write(REG_RSSI_EN, 32'd1);
    reg_write(REG_FADEOUT_EN, 32'd1);
    reg_write(REG_PERSIST_EN, 32'd1);
    reg_write(REG_FADE_LIMIT, 32'd100);
    reg_write(REG_FADE_LIMIT_O, 32'd50);
    random_phase(60);
    drain();

    reg_write(REG_DEVTYPE_VIS, 32'd0);
    reg_write(REG_FADE_LIMIT, 32'd127);
    random_phase(40);
    drain();

    $display("covered %0d requests (%0d ticks), %0d results checked, 5 register settings",
             accepted, n_ticks, n_results);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
